[rtl/two_dimensional_parity_core_macros.svh]
// Assertion macros for the two-dimensional parity core checker.
// Included by the checker module; needs clk and rst_n in scope.
`ifndef TWO_DIMENSIONAL_PARITY_CORE_MACROS_SVH
`define TWO_DIMENSIONAL_PARITY_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define TDP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdp assertion failed");

// Antecedent implies consequent in the next cycle
`define TDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdp assertion failed");

`endif

[rtl/tdp_pkg.sv]
// Shared constants and types for the two-dimensional parity core.
// No dependencies; used by the front, queue, back and top modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

    localparam int MAX_COLS  = 32;
    localparam int MAX_ROWS  = 1024;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 11;
    localparam int CIDX_W    = $clog2(MAX_COLS);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int Q_DEPTH   = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ODD_PARITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 3'd3;

    localparam logic [COL_W-1:0] COLS_RESET = 6'd8;
    localparam logic [ROW_W-1:0] ROWS_RESET = 11'd8;

    // Work descriptor handed from front to back: one per item that yields results
    typedef struct packed {
        logic                is_check;
        logic                err;
        logic                data;
        logic                has_row;
        logic                row_par;
        logic                has_blk;
        logic [MAX_COLS-1:0] col_vec;
        logic                corner;
        logic [COL_W-1:0]    ncols;
    } desc_t;

endpackage

`default_nettype wire

[rtl/tdp_front.sv]
// Front end: configuration registers, parity accumulation and classification.
// Depends on tdp_pkg; pushes descriptors into tdp_queue.
`timescale 1ns / 1ps
`default_nettype none

module tdp_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tdp_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           data_bit,
    input  wire logic                           q_full,
    output logic                                push,
    output tdp_pkg::desc_t                      push_desc
);

    logic                         mode_reg;
    logic                         odd_reg;
    logic [tdp_pkg::COL_W-1:0]    row_length_reg;
    logic [tdp_pkg::ROW_W-1:0]    row_count_reg;

    logic [tdp_pkg::MAX_COLS-1:0] col_par_reg, col_par_next;
    logic                         row_acc_reg, row_acc_next;
    logic                         tot_acc_reg, tot_acc_next;
    logic [tdp_pkg::COL_W-1:0]    col_pos_reg, col_pos_next;
    logic [tdp_pkg::ROW_W-1:0]    row_pos_reg, row_pos_next;
    logic                         mismatch_reg, mismatch_next;

    logic [tdp_pkg::COL_W-1:0]    eff_cols;
    logic [tdp_pkg::ROW_W-1:0]    eff_rows;
    logic [tdp_pkg::CIDX_W-1:0]   j_idx;
    logic [tdp_pkg::COL_W-1:0]    j_inc;
    logic [tdp_pkg::ROW_W-1:0]    r_inc;
    logic [tdp_pkg::MAX_COLS-1:0] bit_mask;
    logic                         accept;
    logic                         cfg_hit;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    // Write to a listed register restarts the block
    always_comb
    begin
        cfg_hit = 1'b0;
        unique case (cfg_index) inside
            tdp_pkg::REG_MODE, tdp_pkg::REG_ODD_PARITY,
            tdp_pkg::REG_ROW_LENGTH, tdp_pkg::REG_ROW_COUNT: cfg_hit = cfg_valid;
            default: cfg_hit = 1'b0;
        endcase
    end

    // Clamp the geometry into range
    always_comb
    begin
        if (row_length_reg == '0)
            eff_cols = tdp_pkg::COL_W'(1);
        else if (row_length_reg > tdp_pkg::COL_W'(tdp_pkg::MAX_COLS))
            eff_cols = tdp_pkg::COL_W'(tdp_pkg::MAX_COLS);
        else
            eff_cols = row_length_reg;

        if (row_count_reg == '0)
            eff_rows = tdp_pkg::ROW_W'(1);
        else if (row_count_reg > tdp_pkg::ROW_W'(tdp_pkg::MAX_ROWS))
            eff_rows = tdp_pkg::ROW_W'(tdp_pkg::MAX_ROWS);
        else
            eff_rows = row_count_reg;
    end

    // Positions stay in range: every register write restarts the block
    assign j_idx    = col_pos_reg[tdp_pkg::CIDX_W-1:0];
    assign j_inc    = col_pos_reg + tdp_pkg::COL_W'(1);
    assign r_inc    = row_pos_reg + tdp_pkg::ROW_W'(1);
    assign bit_mask = tdp_pkg::MAX_COLS'(data_bit) << j_idx;

    // Accumulate and classify the accepted item
    always_comb
    begin
        col_par_next  = col_par_reg;
        row_acc_next  = row_acc_reg;
        tot_acc_next  = tot_acc_reg;
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        mismatch_next = mismatch_reg;
        push          = 1'b0;
        push_desc     = '0;
        push_desc.ncols = eff_cols;

        if (accept)
        begin
            if (!mode_reg)
            begin
                // generate: echo, then row parity, then column parities and corner
                push           = 1'b1;
                push_desc.data = data_bit;
                row_acc_next   = row_acc_reg ^ data_bit;
                tot_acc_next   = tot_acc_reg ^ data_bit;
                col_par_next   = col_par_reg ^ bit_mask;
                if (j_inc < eff_cols)
                begin
                    col_pos_next = j_inc;
                end
                else
                begin
                    push_desc.has_row = 1'b1;
                    push_desc.row_par = row_acc_next ^ odd_reg;
                    row_acc_next      = 1'b0;
                    col_pos_next      = '0;
                    if (r_inc < eff_rows)
                    begin
                        row_pos_next = r_inc;
                    end
                    else
                    begin
                        push_desc.has_blk = 1'b1;
                        push_desc.col_vec = col_par_next ^ {tdp_pkg::MAX_COLS{odd_reg}};
                        push_desc.corner  = tot_acc_next ^ odd_reg;
                        col_par_next      = '0;
                        tot_acc_next      = 1'b0;
                        row_pos_next      = '0;
                        mismatch_next     = 1'b0;
                    end
                end
            end
            else if (row_pos_reg < eff_rows)
            begin
                // check: data rows, each closed by its parity bit
                if (col_pos_reg < eff_cols)
                begin
                    row_acc_next = row_acc_reg ^ data_bit;
                    tot_acc_next = tot_acc_reg ^ data_bit;
                    col_par_next = col_par_reg ^ bit_mask;
                    col_pos_next = j_inc;
                end
                else
                begin
                    if (data_bit != (row_acc_reg ^ odd_reg))
                        mismatch_next = 1'b1;
                    row_acc_next = 1'b0;
                    col_pos_next = '0;
                    row_pos_next = r_inc;
                end
            end
            else if (col_pos_reg < eff_cols)
            begin
                // check: column parity row
                if (data_bit != (col_par_reg[j_idx] ^ odd_reg))
                    mismatch_next = 1'b1;
                col_pos_next = j_inc;
            end
            else
            begin
                // check: corner closes the frame
                push               = 1'b1;
                push_desc.is_check = 1'b1;
                push_desc.err      = mismatch_reg || (data_bit != (tot_acc_reg ^ odd_reg));
                col_par_next       = '0;
                row_acc_next       = 1'b0;
                tot_acc_next       = 1'b0;
                col_pos_next       = '0;
                row_pos_next       = '0;
                mismatch_next      = 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            odd_reg        <= 1'b0;
            row_length_reg <= tdp_pkg::COLS_RESET;
            row_count_reg  <= tdp_pkg::ROWS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tdp_pkg::REG_MODE:       mode_reg       <= cfg_data[0];
                tdp_pkg::REG_ODD_PARITY: odd_reg        <= cfg_data[0];
                tdp_pkg::REG_ROW_LENGTH: row_length_reg <= cfg_data[tdp_pkg::COL_W-1:0];
                tdp_pkg::REG_ROW_COUNT:  row_count_reg  <= cfg_data[tdp_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Accumulator and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_par_reg  <= '0;
            row_acc_reg  <= 1'b0;
            tot_acc_reg  <= 1'b0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            mismatch_reg <= 1'b0;
        end
        else if (cfg_hit)
        begin
            col_par_reg  <= '0;
            row_acc_reg  <= 1'b0;
            tot_acc_reg  <= 1'b0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            mismatch_reg <= 1'b0;
        end
        else
        begin
            col_par_reg  <= col_par_next;
            row_acc_reg  <= row_acc_next;
            tot_acc_reg  <= tot_acc_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            mismatch_reg <= mismatch_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tdp_queue.sv]
// Two-entry descriptor queue between front and back.
// Depends on tdp_pkg for the descriptor type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tdp_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tdp_pkg::desc_t  push_desc,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output tdp_pkg::desc_t       head_desc
);

    tdp_pkg::desc_t                mem_reg [tdp_pkg::Q_DEPTH];
    logic [tdp_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [tdp_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [tdp_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    assign full       = (count_reg == tdp_pkg::QCNT_W'(tdp_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + tdp_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - tdp_pkg::QCNT_W'(1);
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + tdp_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + tdp_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tdp_back.sv]
// Back end: expands the head descriptor into result items, one per cycle while out_ready is high.
// Depends on tdp_pkg; reads the head of tdp_queue.
`timescale 1ns / 1ps
`default_nettype none

module tdp_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire tdp_pkg::desc_t  head_desc,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 out_bit,
    output logic                 is_parity,
    output logic                 last,
    output logic                 frame_end,
    output logic                 error_found
);

    logic [tdp_pkg::COL_W-1:0]  step_reg;
    logic [tdp_pkg::COL_W-1:0]  col_off;
    logic [tdp_pkg::COL_W-1:0]  corner_step;
    logic                       fire;

    assign out_valid   = head_valid;
    assign fire        = out_valid && out_ready;
    assign pop         = fire && last;
    assign col_off     = step_reg - tdp_pkg::COL_W'(2);
    assign corner_step = head_desc.ncols + tdp_pkg::COL_W'(2);

    // Result fields: the check-mode verdict item, else by step: echo, row parity, column parities, corner
    always_comb
    begin
        out_bit     = 1'b0;
        is_parity   = 1'b0;
        last        = 1'b0;
        frame_end   = 1'b0;
        error_found = 1'b0;
        if (head_desc.is_check)
        begin
            last        = 1'b1;
            frame_end   = 1'b1;
            error_found = head_desc.err;
        end
        else if (step_reg == '0)
        begin
            out_bit = head_desc.data;
            last    = !head_desc.has_row;
        end
        else if (step_reg == tdp_pkg::COL_W'(1))
        begin
            out_bit   = head_desc.row_par;
            is_parity = 1'b1;
            last      = !head_desc.has_blk;
        end
        else if (step_reg == corner_step)
        begin
            out_bit   = head_desc.corner;
            is_parity = 1'b1;
            last      = 1'b1;
            frame_end = 1'b1;
        end
        else
        begin
            out_bit   = head_desc.col_vec[col_off[tdp_pkg::CIDX_W-1:0]];
            is_parity = 1'b1;
        end
    end

    // Step within the current descriptor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (pop)
            step_reg <= '0;
        else if (fire)
            step_reg <= step_reg + tdp_pkg::COL_W'(1);
    end

endmodule

`default_nettype wire

[rtl/two_dimensional_parity_core.sv]
// Top level of the two-dimensional parity encoder / checker.
// Depends on tdp_pkg, tdp_front, tdp_queue and tdp_back.
//
// Usage:
//   Input channel (in_valid/in_ready, data_bit) takes the block one bit per
//   item in row-major order. Output channel (out_valid/out_ready) gives
//   out_bit, is_parity, last, frame_end and error_found per result item.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; indexes 0..3 are mode, odd_parity, row_length, row_count, and any
//   such write restarts the block. Write only while the block is idle.
//   With the queue empty, the first result of an item can be taken in the
//   cycle after the item is accepted. Throughput: one item per cycle while
//   each item yields one result and the receiver is ready. In generate mode
//   a row end also yields its row parity; the block end also yields a
//   column parity for each clamped row_length column, and the corner. In
//   check mode only the frame's final bit gives a result.
//   A two-entry descriptor queue parts front and back; in_ready drops only
//   when it is full, so a stalled receiver holds its result while the front
//   takes items until the queue fills. Reset: mode 0, even parity, 8 x 8.
`timescale 1ns / 1ps
`default_nettype none

module two_dimensional_parity_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tdp_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           data_bit,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                out_bit,
    output logic                                is_parity,
    output logic                                last,
    output logic                                frame_end,
    output logic                                error_found
);

    logic            q_full;
    logic            push;
    tdp_pkg::desc_t  push_desc;
    logic            pop;
    logic            head_valid;
    tdp_pkg::desc_t  head_desc;

    tdp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_bit  (data_bit),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    tdp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    tdp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_desc   (head_desc),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_bit     (out_bit),
        .is_parity   (is_parity),
        .last        (last),
        .frame_end   (frame_end),
        .error_found (error_found)
    );

endmodule

`default_nettype wire

[rtl/tdp_checker.sv]
// Port-level checker for the two-dimensional parity core, bound to the top.
// Depends on two_dimensional_parity_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "two_dimensional_parity_core_macros.svh"

module tdp_checker
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_ready,
    input  wire logic  out_valid,
    input  wire logic  out_ready,
    input  wire logic  out_bit,
    input  wire logic  is_parity,
    input  wire logic  last,
    input  wire logic  frame_end,
    input  wire logic  error_found
);

    logic [4:0] out_fields;

    assign out_fields = {out_bit, is_parity, last, frame_end, error_found};

    // A stalled result item holds
    `TDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))

    // The closing item of a frame is always the last of its item
    `TDP_ASSERT_IMP(a_end_is_last, out_valid && frame_end, last)

    // Error flag only on a check-mode frame close
    `TDP_ASSERT_IMP(a_err_at_end, out_valid && error_found, frame_end && !is_parity && !out_bit)

    // Input stalls only while results are waiting
    `TDP_ASSERT_IMP(a_stall_has_out, !in_ready, out_valid)

endmodule

bind two_dimensional_parity_core tdp_checker u_tdp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_bit     (out_bit),
    .is_parity   (is_parity),
    .last        (last),
    .frame_end   (frame_end),
    .error_found (error_found)
);

`default_nettype wire

[tb/two_dimensional_parity_core_test.sv]
`timescale 1ns / 1ps

// Self-checking testbench for two_dimensional_parity_core: parity blocks are encoded
// and frames checked under many register settings, each result item against a local model.
// Depends on tdp_pkg and the core RTL only.

module two_dimensional_parity_core_test;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ROUNDS = 3;
    localparam int TIMEOUT_NS    = 10_000_000;

    // Indexes past the register list; writes there must be ignored
    localparam logic [tdp_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
    localparam logic [tdp_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic out_bit;
        logic is_parity;
        logic last;
        logic frame_end;
        logic error_found;
    } parity_item_t;

    string field_names [5] = '{"out_bit", "is_parity", "last", "frame_end", "error_found"};

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [tdp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tdp_pkg::CFG_DAT_W-1:0] cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          data_bit  = 1'b0;
    logic                          out_ready = 1'b1;
    wire                           cfg_ready;
    wire                           in_ready;
    wire                           out_valid;
    wire                           out_bit;
    wire                           is_parity;
    wire                           last;
    wire                           frame_end;
    wire                           error_found;

    // Local copy of the registers and the parity state
    logic                         mode_q   = 1'b0;
    logic                         odd_q    = 1'b0;
    logic [tdp_pkg::COL_W-1:0]    len_q    = tdp_pkg::COLS_RESET;
    logic [tdp_pkg::ROW_W-1:0]    cnt_q    = tdp_pkg::ROWS_RESET;
    logic [tdp_pkg::MAX_COLS-1:0] col_par  = '0;
    logic                         row_acc  = 1'b0;
    logic                         tot_acc  = 1'b0;
    logic                         mismatch = 1'b0;
    int unsigned                  col_pos  = 0;
    int unsigned                  row_pos  = 0;

    parity_item_t               outputs_due [$];
    logic [tdp_pkg::MAX_COLS:0] frame_rows [0:tdp_pkg::MAX_ROWS];
    bit                         idling         = 1'b1;
    int unsigned                mismatch_count = 0;

    two_dimensional_parity_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_bit    (data_bit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_bit     (out_bit),
        .is_parity   (is_parity),
        .last        (last),
        .frame_end   (frame_end),
        .error_found (error_found)
    );

    always #5 clk = ~clk;

    // Lengths outside the legal range are clamped
    function automatic int unsigned eff_cols();
        if (len_q == '0)
            return 1;
        if (32'(len_q) > tdp_pkg::MAX_COLS)
            return tdp_pkg::MAX_COLS;
        return 32'(len_q);
    endfunction

    function automatic int unsigned eff_rows();
        if (cnt_q == '0)
            return 1;
        if (32'(cnt_q) > tdp_pkg::MAX_ROWS)
            return tdp_pkg::MAX_ROWS;
        return 32'(cnt_q);
    endfunction

    function automatic void clear_parity_state();
        col_par  = '0;
        row_acc  = 1'b0;
        tot_acc  = 1'b0;
        mismatch = 1'b0;
        col_pos  = 0;
        row_pos  = 0;
    endfunction

    // No gap unless idling; then mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (!idling)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 16);
    endfunction

    // Advance the parity state by one accepted bit and queue the items it yields
    task automatic compute_outputs(input logic b);
        parity_item_t burst [$];
        parity_item_t tail;
        int unsigned  cols;
        int unsigned  rows;
        int unsigned  j;
        cols = eff_cols();
        rows = eff_rows();
        j    = col_pos;
        if (j > cols)
            j = cols;
        if (row_pos > rows)
            row_pos = rows;
        if (!mode_q)
        begin
            // generate: echo, then row parity, then column parities and corner
            if (j >= cols)
                j = cols - 1;
            burst.push_back('{b, 1'b0, 1'b0, 1'b0, 1'b0});
            row_acc    ^= b;
            tot_acc    ^= b;
            col_par[j] ^= b;
            if (j + 1 < cols)
                col_pos = j + 1;
            else
            begin
                burst.push_back('{row_acc ^ odd_q, 1'b1, 1'b0, 1'b0, 1'b0});
                row_acc = 1'b0;
                col_pos = 0;
                if (row_pos + 1 < rows)
                    row_pos++;
                else
                begin
                    for (int c = 0; c < cols; c++)
                        burst.push_back('{col_par[c] ^ odd_q, 1'b1, 1'b0, 1'b0, 1'b0});
                    burst.push_back('{tot_acc ^ odd_q, 1'b1, 1'b0, 1'b1, 1'b0});
                    clear_parity_state();
                end
            end
            tail      = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
        else if (row_pos < rows)
        begin
            // check: data bits accumulate, the row's extra bit is its parity
            if (j < cols)
            begin
                row_acc    ^= b;
                tot_acc    ^= b;
                col_par[j] ^= b;
                col_pos     = j + 1;
            end
            else
            begin
                if (b != (row_acc ^ odd_q))
                    mismatch = 1'b1;
                row_acc = 1'b0;
                col_pos = 0;
                row_pos++;
            end
        end
        else if (j < cols)
        begin
            if (b != (col_par[j] ^ odd_q))
                mismatch = 1'b1;
            col_pos = j + 1;
        end
        else
        begin
            // corner closes the frame with the single verdict item
            if (b != (tot_acc ^ odd_q))
                mismatch = 1'b1;
            burst.push_back('{1'b0, 1'b0, 1'b1, 1'b1, mismatch});
            clear_parity_state();
        end
        foreach (burst[k])
            outputs_due.push_back(burst[k]);
    endtask

    // Present one bit, wait for acceptance, then maybe idle
    task automatic send_item(input logic b);
        int gap;
        in_valid <= 1'b1;
        data_bit <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        compute_outputs(b);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            data_bit <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_bits(input int unsigned n);
        repeat (n) send_item(1'($urandom_range(0, 1)));
    endtask

    // Stop sending, wait for every expected item, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        while (outputs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tdp_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= tdp_pkg::CFG_DAT_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            tdp_pkg::REG_MODE:       mode_q = val[0];
            tdp_pkg::REG_ODD_PARITY: odd_q  = val[0];
            tdp_pkg::REG_ROW_LENGTH: len_q  = val[tdp_pkg::COL_W-1:0];
            tdp_pkg::REG_ROW_COUNT:  cnt_q  = val[tdp_pkg::ROW_W-1:0];
            default: ;
        endcase
        // any write to a real register restarts the block
        if (idx <= tdp_pkg::REG_ROW_COUNT)
            clear_parity_state();
    endtask

    // Build a correct frame of random data for the current geometry, then invert a random bit flips times
    task automatic send_check_frame(input int unsigned flips);
        int unsigned                  cols;
        int unsigned                  rows;
        int unsigned                  r;
        int unsigned                  c;
        logic [tdp_pkg::MAX_COLS:0]   row_bits;
        logic [tdp_pkg::MAX_COLS-1:0] col_acc;
        logic                         tot;
        logic                         rp;
        logic                         b;
        cols    = eff_cols();
        rows    = eff_rows();
        col_acc = '0;
        tot     = 1'b0;
        for (r = 0; r < rows; r++)
        begin
            row_bits = '0;
            rp       = odd_q;
            for (c = 0; c < cols; c++)
            begin
                b           = 1'($urandom_range(0, 1));
                row_bits[c] = b;
                rp         ^= b;
                col_acc[c] ^= b;
                tot        ^= b;
            end
            row_bits[cols] = rp;
            frame_rows[r]  = row_bits;
        end
        row_bits = '0;
        for (c = 0; c < cols; c++)
            row_bits[c] = col_acc[c] ^ odd_q;
        row_bits[cols]   = tot ^ odd_q;
        frame_rows[rows] = row_bits;
        repeat (flips)
        begin
            r = $urandom_range(0, rows);
            c = $urandom_range(0, cols);
            frame_rows[r][c] = ~frame_rows[r][c];
        end
        for (r = 0; r <= rows; r++)
            for (c = 0; c <= cols; c++)
                send_item(frame_rows[r][c]);
    endtask

    // 2 x 2 frame of a one-bit block: data, row parity, column parity, corner
    task automatic send_tiny_frame(input logic [3:0] bits);
        for (int k = 3; k >= 0; k--)
            send_item(bits[k]);
    endtask

    // Reset geometry is 8 x 8, even parity, generate mode: one full row
    task automatic test_reset_geometry();
        send_random_bits(eff_cols());
    endtask

    task automatic test_directed_generate();
        write_reg(tdp_pkg::REG_ROW_LENGTH, 1);
        write_reg(tdp_pkg::REG_ROW_COUNT, 1);
        send_item(1'b0);
        send_item(1'b1);
        // only bit 0 of the register counts
        write_reg(tdp_pkg::REG_ODD_PARITY, 32'h7FF);
        send_item(1'b0);
        send_item(1'b1);
        write_reg(tdp_pkg::REG_MODE, 32'h7FE);
        // zero lengths act as one
        write_reg(tdp_pkg::REG_ROW_LENGTH, 0);
        write_reg(tdp_pkg::REG_ROW_COUNT, 0);
        send_item(1'b1);
        send_item(1'b0);
        write_reg(tdp_pkg::REG_ODD_PARITY, 0);
        write_reg(tdp_pkg::REG_ROW_LENGTH, 2);
        write_reg(tdp_pkg::REG_ROW_COUNT, 2);
        send_item(1'b1);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
    endtask

    task automatic test_directed_check();
        write_reg(tdp_pkg::REG_MODE, 32'h401);
        write_reg(tdp_pkg::REG_ROW_LENGTH, 1);
        write_reg(tdp_pkg::REG_ROW_COUNT, 1);
        send_tiny_frame(4'b1111);
        send_tiny_frame(4'b1110);   // bad corner
        write_reg(tdp_pkg::REG_ODD_PARITY, 1);
        send_tiny_frame(4'b0111);
        send_tiny_frame(4'b0011);   // bad row parity
        send_tiny_frame(4'b0101);   // bad column parity
    endtask

    task automatic test_restart_rules();
        write_reg(tdp_pkg::REG_MODE, 0);
        write_reg(tdp_pkg::REG_ODD_PARITY, 0);
        write_reg(tdp_pkg::REG_ROW_LENGTH, 2);
        write_reg(tdp_pkg::REG_ROW_COUNT, 2);
        // a spare index mid-block must leave the block running
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        write_reg(tdp_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  $urandom);
        send_item(1'b1);
        // a real register mid-block restarts it
        send_item(1'b1);
        send_item(1'b1);
        send_item(1'b0);
        write_reg(tdp_pkg::REG_ROW_COUNT, 2);
        send_random_bits(4);
        // restart mid-frame also clears any mismatch seen so far
        write_reg(tdp_pkg::REG_MODE, 1);
        send_random_bits(5);
        write_reg(tdp_pkg::REG_ODD_PARITY, 1);
        send_check_frame(0);
    endtask

    task automatic test_extreme_sizes();
        // widest row clamps to MAX_COLS: the closing bit yields the most items
        write_reg(tdp_pkg::REG_MODE, 0);
        write_reg(tdp_pkg::REG_ODD_PARITY, $urandom_range(0, 1));
        write_reg(tdp_pkg::REG_ROW_LENGTH, 63);
        write_reg(tdp_pkg::REG_ROW_COUNT, 1);
        send_random_bits(eff_cols() * eff_rows());
        // row count clamps to MAX_ROWS: the block stays open
        write_reg(tdp_pkg::REG_ROW_LENGTH, 1);
        write_reg(tdp_pkg::REG_ROW_COUNT, 32'h7FF);
        send_random_bits(3);
        // check mode with a zero row length
        write_reg(tdp_pkg::REG_MODE, 1);
        write_reg(tdp_pkg::REG_ROW_LENGTH, 0);
        write_reg(tdp_pkg::REG_ROW_COUNT, 1);
        send_check_frame(1);
    endtask

    // Random settings, mostly well-formed blocks and frames, some noise
    task automatic test_random_traffic();
        int unsigned roll;
        int unsigned len_val;
        int unsigned cnt_val;
        repeat (RANDOM_ROUNDS)
        begin
            idling = ($urandom_range(0, 3) != 0);
            roll   = $urandom_range(0, 9);
            if (roll < 8)
                len_val = $urandom_range(1, 3);
            else
                len_val = 0;
            roll = $urandom_range(0, 9);
            if (roll < 8)
                cnt_val = $urandom_range(1, 2);
            else
                cnt_val = 0;
            write_reg(tdp_pkg::REG_MODE, $urandom_range(0, 1));
            if ($urandom_range(0, 1))
                write_reg(tdp_pkg::REG_ODD_PARITY, $urandom);
            write_reg(tdp_pkg::REG_ROW_LENGTH, len_val);
            write_reg(tdp_pkg::REG_ROW_COUNT, cnt_val);
            roll = $urandom_range(0, 9);
            if (roll >= 8)
                send_random_bits($urandom_range(1, eff_cols() * eff_rows()));
            else if (mode_q)
                send_check_frame($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
            else
                send_random_bits(eff_cols() * eff_rows());
        end
        idling = 1'b1;
    endtask

    // Receiver side: random stalls on out_ready
    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result item with the oldest one due
    always @(posedge clk)
    begin : check_results
        parity_item_t seen;
        parity_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{out_bit, is_parity, last, frame_end, error_found};
            if (outputs_due.size() == 0)
            begin
                $display("%0t: result item %b arrived with none due", $time, seen);
                mismatch_count++;
            end
            else
            begin
                want = outputs_due.pop_front();
                for (int i = 0; i < 5; i++)
                    if (seen[4 - i] !== want[4 - i])
                    begin
                        $display("%0t: %s expected %b actual %b", $time, field_names[i],
                                 want[4 - i], seen[4 - i]);
                        mismatch_count++;
                    end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_directed_generate();
        test_directed_check();
        test_restart_rules();
        test_extreme_sizes();
        test_random_traffic();
        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #TIMEOUT_NS;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tdp_pkg.sv
rtl/tdp_front.sv
rtl/tdp_queue.sv
rtl/tdp_back.sv
rtl/two_dimensional_parity_core.sv
rtl/tdp_checker.sv
tb/two_dimensional_parity_core_test.sv
